// ===== sv/tail_drop_packet_buffer_core_macros.svh =====
// Assertion macros shared by the packet buffer RTL.
`ifndef TAIL_DROP_PACKET_BUFFER_CORE_MACROS_SVH
`define TAIL_DROP_PACKET_BUFFER_CORE_MACROS_SVH

// Checks an implication that must hold in the same cycle.
`define TDPB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks an implication whose consequence is seen in the next cycle.
`define TDPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tdpb_pkg.sv =====
// Shared widths and constants for the tail-drop packet buffer.
package tdpb_pkg;

  localparam int TIME_W = 48;
  localparam int ARR_W  = 32;
  localparam int PT_W   = 16;
  localparam int BS_W   = 5;

  localparam logic [BS_W-1:0] BS_RESET = 5'd16;

  typedef logic [TIME_W-1:0] time_t;

endpackage

// ===== sv/tdpb_store.sv =====
// Finish-time store: one write port, one registered read port with write forwarding.
module tdpb_store
  import tdpb_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  time_t             wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output time_t             rd_data
);

  time_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write to the entry being read is passed straight to the read data.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tail_drop_packet_buffer_core.sv =====
// A word accepted in idle waits while the retire state drops each expired head entry in turn;
// its result is then loaded once the output register is empty or not held by res_stall.
// A new word is taken the cycle after the previous result is loaded.
// The result sits in an output register, so the input is taken while it waits.
// Reset clears pointers, occupancy and output valid, and sets buffer_size to 16.
// The finish-time store is not cleared; only entries inside the occupancy are read.
`include "tail_drop_packet_buffer_core_macros.svh"

module tail_drop_packet_buffer_core
  import tdpb_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [BS_W-1:0]   wr_data,
  input  logic              pkt_valid,
  output logic              pkt_stall,
  input  logic [ARR_W-1:0]  arr_time,
  input  logic [PT_W-1:0]   svc_time,
  output logic              res_valid,
  input  logic              res_stall,
  output logic              dropped,
  output logic [TIME_W-1:0] svc_start
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > BS_W) ? OCC_W : BS_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0] CAP_MAX  = CMP_W'(DEPTH);

  typedef enum logic {S_IDLE, S_RETIRE} state_t;

  state_t           state;
  logic [BS_W-1:0]  buffer_size;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] head_ptr_next;
  logic [PTR_W-1:0] tail_ptr;
  logic [OCC_W-1:0] occupancy;
  logic [ARR_W-1:0] arr_q;
  logic [PT_W-1:0]  pt_q;
  time_t            last_finish;
  time_t            head_finish;

  logic             retire;
  logic             out_free;
  logic             decide;
  logic             full;
  logic             push;
  logic [CMP_W-1:0] cap;
  logic [CMP_W-1:0] bs_ext;
  time_t            start_calc;
  time_t            finish_calc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    bs_ext = CMP_W'(buffer_size);
    priority if (bs_ext == '0) begin
      cap = CMP_W'(1);
    end else if (bs_ext > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = bs_ext;
    end
  end

  always_comb begin
    retire      = (occupancy != '0) && (head_finish <= TIME_W'(arr_q));
    out_free    = !res_valid || !res_stall;
    decide      = (state == S_RETIRE) && !retire && out_free;
    full        = CMP_W'(occupancy) >= cap;
    push        = decide && !full;
    start_calc  = (occupancy == '0) ? TIME_W'(arr_q) : last_finish;
    finish_calc = start_calc + TIME_W'(pt_q);
    // The store reads the next head every cycle, so its output tracks the head entry.
    head_ptr_next = ((state == S_RETIRE) && retire) ? ptr_inc(head_ptr) : head_ptr;
  end

  assign pkt_stall = (state != S_IDLE);

  tdpb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail_ptr),
    .wr_data (finish_calc),
    .rd_addr (head_ptr_next),
    .rd_data (head_finish)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      buffer_size <= BS_RESET;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      occupancy   <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        buffer_size <= wr_data;
      end
      if (decide) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      head_ptr <= head_ptr_next;
      unique case (state)
        S_IDLE: begin
          if (pkt_valid) begin
            arr_q <= arr_time;
            pt_q  <= svc_time;
            state <= S_RETIRE;
          end
        end
        S_RETIRE: begin
          if (retire) begin
            occupancy <= occupancy - OCC_W'(1);
          end else if (out_free) begin
            state <= S_IDLE;
            if (full) begin
              dropped   <= 1'b1;
              svc_start <= '0;
            end else begin
              dropped     <= 1'b0;
              svc_start   <= start_calc;
              last_finish <= finish_calc;
              tail_ptr    <= ptr_inc(tail_ptr);
              occupancy   <= occupancy + OCC_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TDPB_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, occupancy <= OCC_W'(DEPTH), "occupancy above depth")
  `TDPB_ASSERT_NOW(a_empty_ptrs, clk, rst, occupancy == '0, head_ptr == tail_ptr, "empty queue with pointers apart")
  `TDPB_ASSERT_NOW(a_drop_zero, clk, rst, res_valid && dropped, svc_start == '0, "dropped word with nonzero start")
  `TDPB_ASSERT_NEXT(a_retire_dec, clk, rst, (state == S_RETIRE) && retire, occupancy == $past(occupancy) - OCC_W'(1), "retire did not lower occupancy")
  `TDPB_ASSERT_NOW(a_push_room, clk, rst, push, CMP_W'(occupancy) < cap, "push into a full queue")

endmodule
